@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros
// Assertion macros for the windowed sample statistics block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked on every clock edge outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/wss_pkg.sv @@
// ---------------------------------------------------------------------------
// wss_pkg
// Types and constants shared by the windowed sample statistics block.
// ---------------------------------------------------------------------------
`default_nettype none
package wss_pkg;
   localparam int unsigned DEPTH = 1024;
   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH);
   localparam logic [31:0] WINDOW_RESET = 32'd16500;
   localparam logic [19:0] RATE_SCALE = 20'd1000000;

   localparam logic [1:0] MODE_PUSH  = 2'd0;
   localparam logic [1:0] MODE_QUERY = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // shared divider use during the mean and mean-square passes
   localparam logic [1:0] DIV_MEAN    = 2'd0;
   localparam logic [1:0] DIV_MEAN_SQ = 2'd1;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] sample;
      logic [31:0]        time_ms;
   } req_type;

   typedef struct packed {
      logic [9:0]         count;
      logic               empty_res;
      logic [31:0]        rate_mhz;
      logic signed [15:0] mean;
      logic [15:0]        rms;
      logic signed [15:0] minimum;
      logic signed [15:0] maximum;
      logic [15:0]        crest_q8;
      logic signed [15:0] newest;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN_RD, ST_SCAN, ST_ACC_RD, ST_ACC, ST_SPAN_RD, ST_SPAN,
      ST_NEWEST, ST_DIV, ST_DIV_WAIT, ST_SQRT, ST_CREST, ST_CREST_WAIT,
      ST_RATE, ST_RATE_WAIT, ST_DONE
   } state_type;

   // divider handshake
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic [63:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

@@ rtl/wss_ram.sv @@
// ---------------------------------------------------------------------------
// wss_ram
// Generic single-port synchronous RAM, registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module wss_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

@@ rtl/wss_div.sv @@
// ---------------------------------------------------------------------------
// wss_div
// Unsigned 64 by 64 restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module wss_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wss_pkg::div_req_type req,
   output wss_pkg::div_rsp_type      rsp
);
   logic [63:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [64:0] trial;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, quo_ff[63]} - {1'b0, den_ff};
      if (req.start) begin
         rem_in = '0;
         quo_in = req.dividend;
         den_in = req.divisor;
         cnt_in = 7'd64;
      end else if (cnt_ff != 7'd0) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.busy     = (cnt_ff != 7'd0);
   assign rsp.quotient = quo_ff;
endmodule
`default_nettype wire

@@ rtl/wss_sqrt.sv @@
// ---------------------------------------------------------------------------
// wss_sqrt
// Floor square root of a 32-bit value, one result bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module wss_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] radicand,
   output logic             busy,
   output logic [15:0]      root
);
   logic [31:0] x_ff, x_in, r_ff, r_in, bit_ff, bit_in;
   logic [4:0]  cnt_ff, cnt_in;

   always_comb begin
      x_in   = x_ff;
      r_in   = r_ff;
      bit_in = bit_ff;
      cnt_in = cnt_ff;
      if (start) begin
         x_in   = radicand;
         r_in   = '0;
         bit_in = 32'h4000_0000;
         cnt_in = 5'd16;
      end else if (cnt_ff != 5'd0) begin
         if (x_ff >= r_ff + bit_ff) begin
            x_in = x_ff - (r_ff + bit_ff);
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      x_ff   <= x_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign busy = (cnt_ff != 5'd0);
   assign root = r_ff[15:0];
endmodule
`default_nettype wire

@@ rtl/windowed_sample_statistics.sv @@
// ---------------------------------------------------------------------------
// windowed_sample_statistics
// Ring of timestamped samples with windowed min, max, mean, RMS, crest and rate.
// ---------------------------------------------------------------------------
// A push or a clear leaves busy low, so the next item may follow at once.
// A query walks the ring through the sample and time RAMs, each entry
// addressed, then compared or accumulated: first the stale entries are
// skipped, then the window is accumulated. Mean, mean square, crest and
// rate then pass through a shared bit-serial divider (up to four uses) and
// a 16-step square root; an empty window skips both. The result is shown
// for one cycle on rsp_valid, in the cycle in which busy falls; the receiver
// cannot stall it. Configuration writes are always ready.
`default_nettype none
`include "assert_macros.svh"
module windowed_sample_statistics (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire wss_pkg::req_type req_data,
   output logic                  rsp_valid,
   output wss_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [31:0]      csr_data
);
   localparam int unsigned AW = wss_pkg::AW;
   localparam int unsigned CW = wss_pkg::CW;

   wss_pkg::state_type state_ff, state_in;
   logic [31:0] window_ff;
   logic [AW-1:0] wp_ff, wp_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [31:0]   now_ff, now_in;
   logic [CW-1:0] idx_ff, idx_in;   // offset from oldest
   logic [CW-1:0] first_ff, first_in;
   logic signed [AW+16:0] sum_ff, sum_in;
   logic [AW+31:0] sq_ff, sq_in;
   logic signed [15:0] mn_ff, mn_in, mx_ff, mx_in, newest_ff, newest_in;
   logic [31:0] t0_ff, t0_in;
   logic [32:0] span_ff, span_in;
   logic signed [15:0] mean_ff, mean_in;
   logic [15:0] rms_ff, rms_in, crest_ff, crest_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] sqin_ff, sqin_in;
   logic        rsp_valid_in, rsp_valid_ff;
   logic [AW-1:0] oldest, addr;
   logic        we;
   logic signed [15:0] s_rd;
   logic [31:0] t_rd;
   logic [CW-1:0] n;
   logic [1:0]  divsel_ff, divsel_in;   // mean or mean square pass
   wss_pkg::div_req_type div_req;
   wss_pkg::div_rsp_type div_rsp;
   logic        sq_start, sq_busy;
   logic [15:0] sq_root;
   logic signed [16:0] pk_a, pk_b;
   logic [16:0] peak;
   logic [33:0] age;
   logic [AW+16:0] abs_sum;
   logic [31:0] sq_v;

   function automatic logic [29:0] RATE_MUL(input logic [CW-1:0] k);
      RATE_MUL = 30'(k) * 30'(wss_pkg::RATE_SCALE);
   endfunction

   assign oldest = wp_ff - AW'(fill_ff);
   assign n      = fill_ff - first_ff;

   // sample ring and time ring
   wss_ram #(.WIDTH(16), .DEPTH(wss_pkg::DEPTH)) u_sample_ram (
      .clock(clock), .wr_en(we), .addr(addr),
      .wr_data(req_data.sample), .rd_data(s_rd));
   wss_ram #(.WIDTH(32), .DEPTH(wss_pkg::DEPTH)) u_time_ram (
      .clock(clock), .wr_en(we), .addr(addr),
      .wr_data(req_data.time_ms), .rd_data(t_rd));
   wss_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));
   wss_sqrt u_sqrt (.clock(clock), .reset(reset), .start(sq_start),
      .radicand(sqin_ff), .busy(sq_busy), .root(sq_root));

   assign csr_ready = 1'b1;
   assign busy = (state_ff != wss_pkg::ST_IDLE);

   always_comb begin
      pk_a = mn_ff[15] ? -{mn_ff[15], mn_ff} : {mn_ff[15], mn_ff};
      pk_b = mx_ff[15] ? -{mx_ff[15], mx_ff} : {mx_ff[15], mx_ff};
      peak = (pk_a > pk_b) ? 17'(pk_a) : 17'(pk_b);
      age  = {2'b0, now_ff} - {2'b0, t_rd};
      abs_sum = sum_ff[AW+16] ? (AW+17)'(-sum_ff) : (AW+17)'(sum_ff);
      sq_v = 32'(32'(s_rd) * 32'(s_rd));
   end

   always_comb begin
      state_in = state_ff;
      wp_in = wp_ff; fill_in = fill_ff; now_in = now_ff;
      idx_in = idx_ff; first_in = first_ff;
      sum_in = sum_ff; sq_in = sq_ff; mn_in = mn_ff; mx_in = mx_ff;
      newest_in = newest_ff; t0_in = t0_ff; span_in = span_ff;
      mean_in = mean_ff; rms_in = rms_ff; crest_in = crest_ff; rate_in = rate_ff;
      sqin_in = sqin_ff; divsel_in = divsel_ff;
      rsp_valid_in = 1'b0;
      we = 1'b0;
      addr = oldest + AW'(idx_ff);
      div_req = '0;
      sq_start = 1'b0;
      case (state_ff)
         wss_pkg::ST_IDLE: begin
            addr = wp_ff;
            if (start) begin
               now_in = req_data.time_ms;
               case (req_data.mode)
                  wss_pkg::MODE_PUSH: begin
                     we = 1'b1;
                     wp_in = wp_ff + AW'(1);
                     if (fill_ff != CW'(wss_pkg::DEPTH - 1)) fill_in = fill_ff + CW'(1);
                  end
                  wss_pkg::MODE_CLEAR: begin
                     wp_in = '0;
                     fill_in = '0;
                  end
                  wss_pkg::MODE_QUERY: begin
                     idx_in = '0;
                     state_in = wss_pkg::ST_SCAN_RD;
                  end
                  default: ;
               endcase
            end
         end
         wss_pkg::ST_SCAN_RD: begin
            // read issued for idx_ff
            if (idx_ff == fill_ff) begin
               first_in = fill_ff;
               state_in = wss_pkg::ST_NEWEST;
            end else begin
               state_in = wss_pkg::ST_SCAN;
            end
         end
         wss_pkg::ST_SCAN: begin
            // age may be negative: bit 33 marks a future timestamp
            if (age[33] || age[32:0] <= {1'b0, window_ff}) begin
               first_in = idx_ff;
               t0_in = t_rd;
               sum_in = '0; sq_in = '0;
               state_in = wss_pkg::ST_ACC_RD;
            end else begin
               idx_in = idx_ff + CW'(1);
               state_in = wss_pkg::ST_SCAN_RD;
            end
         end
         wss_pkg::ST_ACC_RD: begin
            state_in = wss_pkg::ST_ACC;
         end
         wss_pkg::ST_ACC: begin
            sum_in = sum_ff + (AW+17)'(s_rd);
            sq_in = sq_ff + (AW+32)'(sq_v);
            if (idx_ff == first_ff || s_rd < mn_ff) mn_in = s_rd;
            if (idx_ff == first_ff || s_rd > mx_ff) mx_in = s_rd;
            if (idx_ff == fill_ff - CW'(1)) begin
               span_in = {1'b0, t_rd} - {1'b0, t0_ff};
               state_in = wss_pkg::ST_NEWEST;
            end else begin
               idx_in = idx_ff + CW'(1);
               state_in = wss_pkg::ST_ACC_RD;
            end
         end
         wss_pkg::ST_SPAN_RD: begin
            // keep the newest entry addressed so its data is seen in ST_SPAN
            addr = wp_ff - AW'(1);
            state_in = wss_pkg::ST_SPAN;
         end
         wss_pkg::ST_SPAN: begin
            newest_in = (fill_ff != '0) ? s_rd : 16'sd0;
            if (n == '0) begin
               mean_in = '0; rms_in = '0; crest_in = '0; rate_in = '0;
               mn_in = '0; mx_in = '0;
               state_in = wss_pkg::ST_DONE;
            end else begin
               divsel_in = wss_pkg::DIV_MEAN;
               state_in = wss_pkg::ST_DIV;
            end
         end
         wss_pkg::ST_NEWEST: begin
            addr = wp_ff - AW'(1);
            state_in = wss_pkg::ST_SPAN_RD;
         end
         wss_pkg::ST_DIV: begin
            div_req.start = 1'b1;
            div_req.divisor = 64'(n);
            div_req.dividend = (divsel_ff == wss_pkg::DIV_MEAN) ? 64'(abs_sum) : 64'(sq_ff);
            state_in = wss_pkg::ST_DIV_WAIT;
         end
         wss_pkg::ST_DIV_WAIT: begin
            if (!div_rsp.busy) begin
               if (divsel_ff == wss_pkg::DIV_MEAN) begin
                  mean_in = sum_ff[AW+16] ? -div_rsp.quotient[15:0]
                                          : div_rsp.quotient[15:0];
                  divsel_in = wss_pkg::DIV_MEAN_SQ;
                  state_in = wss_pkg::ST_DIV;
               end else begin
                  sqin_in = div_rsp.quotient[31:0];
                  state_in = wss_pkg::ST_SQRT;
                  sq_start = 1'b0;
               end
            end
         end
         wss_pkg::ST_SQRT: begin
            sq_start = 1'b1;
            state_in = wss_pkg::ST_CREST;
         end
         wss_pkg::ST_CREST: begin
            if (!sq_busy) begin
               rms_in = sq_root;
               if (sq_root == '0) begin
                  crest_in = (peak == '0) ? 16'd0 : 16'hFFFF;
                  state_in = wss_pkg::ST_RATE;
               end else begin
                  div_req.start = 1'b1;
                  div_req.dividend = 64'({peak, 8'd0});
                  div_req.divisor = 64'(sq_root);
                  state_in = wss_pkg::ST_CREST_WAIT;
               end
            end
         end
         wss_pkg::ST_CREST_WAIT: begin
            if (!div_rsp.busy) begin
               crest_in = (div_rsp.quotient > 64'hFFFF) ? 16'hFFFF
                                                       : div_rsp.quotient[15:0];
               state_in = wss_pkg::ST_RATE;
            end
         end
         wss_pkg::ST_RATE: begin
            if (n < CW'(2) || span_ff[32]) begin
               rate_in = '0;
               state_in = wss_pkg::ST_DONE;
            end else if (span_ff == '0) begin
               rate_in = 32'hFFFF_FFFF;
               state_in = wss_pkg::ST_DONE;
            end else begin
               div_req.start = 1'b1;
               div_req.dividend = 64'(RATE_MUL(n - CW'(1)));
               div_req.divisor = 64'(span_ff[31:0]);
               state_in = wss_pkg::ST_RATE_WAIT;
            end
         end
         wss_pkg::ST_RATE_WAIT: begin
            if (!div_rsp.busy) begin
               rate_in = (div_rsp.quotient > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                           : div_rsp.quotient[31:0];
               state_in = wss_pkg::ST_DONE;
            end
         end
         wss_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = wss_pkg::ST_IDLE;
         end
         default: state_in = wss_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wss_pkg::ST_IDLE;
         window_ff <= wss_pkg::WINDOW_RESET;
         wp_ff <= '0;
         fill_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wp_ff <= wp_in;
         fill_ff <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) window_ff <= csr_data;
      end
      now_ff <= now_in; idx_ff <= idx_in; first_ff <= first_in;
      sum_ff <= sum_in; sq_ff <= sq_in; mn_ff <= mn_in; mx_ff <= mx_in;
      newest_ff <= newest_in; t0_ff <= t0_in; span_ff <= span_in;
      mean_ff <= mean_in; rms_ff <= rms_in; crest_ff <= crest_in;
      rate_ff <= rate_in; sqin_ff <= sqin_in; divsel_ff <= divsel_in;
   end

   assign rsp_valid = rsp_valid_ff;
   always_comb begin
      rsp_data.count     = n;
      rsp_data.empty_res = (n == '0);
      rsp_data.rate_mhz  = rate_ff;
      rsp_data.mean      = mean_ff;
      rsp_data.rms       = rms_ff;
      rsp_data.minimum   = mn_ff;
      rsp_data.maximum   = mx_ff;
      rsp_data.crest_q8  = crest_ff;
      rsp_data.newest    = newest_ff;
   end

   // a result strobe only follows the final query step
   `ASSERT_NEXT(a_rsp_after_done, clock, reset, state_ff == wss_pkg::ST_DONE, rsp_valid, "no result")
   `ASSERT_IMPL(a_rsp_idle, clock, reset, rsp_valid, !busy, "result while busy")
   `ASSERT_IMPL(a_no_write_busy, clock, reset, busy, !we, "ring written during a query")
endmodule
`default_nettype wire

@@ dv/tb_windowed_sample_statistics.sv @@
// ---------------------------------------------------------------------------
// tb_windowed_sample_statistics
// Self-checking bench: pushes, queries and clears are driven through the
// start/busy port, a local ring model predicts every query result and each
// rsp_valid item is compared field by field against the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_windowed_sample_statistics;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_SPARE = 2'd3;   // unused code, block ignores it

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   wss_pkg::req_type req_data = '0;
   logic             rsp_valid;
   wss_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [31:0]      csr_data = '0;

   windowed_sample_statistics uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // local copy of the ring and the window register
   logic signed [15:0] ring_sample [wss_pkg::DEPTH];
   logic [31:0]        ring_time [wss_pkg::DEPTH];
   int unsigned        wr_ptr;
   int unsigned        fill;
   logic [31:0]        window_reg = wss_pkg::WINDOW_RESET;

   wss_pkg::rsp_type stats_due [$];   // predicted query results, oldest first
   int          errors = 0;
   int          idle_pct = 0;    // chance of a sender gap before an item
   int          n_push = 0, n_query = 0, n_clear = 0, n_rsp = 0;
   logic [31:0] now_ms = '0;

   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // statistics of the window seen from time 'now'
   function automatic wss_pkg::rsp_type window_stats(logic [31:0] now);
      wss_pkg::rsp_type r = '0;
      int unsigned     oldest, first, n, k;
      longint          sum = 0, mn = 0, mx = 0, v, peak, span;
      longint unsigned sumsq = 0, rms = 0, crest = 0, rate = 0;
      oldest = (wr_ptr + wss_pkg::DEPTH - fill) % wss_pkg::DEPTH;
      for (first = 0; first < fill; first++) begin
         if (longint'(now) - longint'(ring_time[(oldest + first) % wss_pkg::DEPTH])
             <= longint'(window_reg))
            break;
      end
      n = fill - first;
      for (int unsigned j = first; j < fill; j++) begin
         v = ring_sample[(oldest + j) % wss_pkg::DEPTH];
         sum += v;
         sumsq += longint'(v * v);
         if (j == first || v < mn) mn = v;
         if (j == first || v > mx) mx = v;
      end
      if (n > 0) begin
         rms = floor_sqrt(sumsq / n);
         peak = (mn < 0) ? -mn : mn;
         if (((mx < 0) ? -mx : mx) > peak) peak = (mx < 0) ? -mx : mx;
         if (rms == 0) crest = (peak == 0) ? 0 : 65535;
         else begin
            crest = (longint'(peak) * 256) / rms;
            if (crest > 65535) crest = 65535;
         end
         if (n >= 2) begin
            k = (oldest + fill - 1) % wss_pkg::DEPTH;
            span = longint'(ring_time[k])
                 - longint'(ring_time[(oldest + first) % wss_pkg::DEPTH]);
            if (span == 0) rate = 64'hFFFF_FFFF;
            else if (span > 0) begin
               rate = (64'd1000000 * (n - 1)) / span;
               if (rate > 64'hFFFF_FFFF) rate = 64'hFFFF_FFFF;
            end
         end
         r.mean = 16'(sum / longint'(n));
      end
      r.count     = 10'(n);
      r.empty_res = (n == 0);
      r.rate_mhz  = 32'(rate);
      r.rms       = 16'(rms);
      r.minimum   = 16'(mn);
      r.maximum   = 16'(mx);
      r.crest_q8  = 16'(crest);
      r.newest    = (fill > 0) ? ring_sample[(wr_ptr + wss_pkg::DEPTH - 1) % wss_pkg::DEPTH]
                               : '0;
      return r;
   endfunction

   // update the model for an accepted item
   function automatic void apply_item(wss_pkg::req_type it);
      case (it.mode)
         wss_pkg::MODE_PUSH: begin
            ring_sample[wr_ptr] = it.sample;
            ring_time[wr_ptr]   = it.time_ms;
            wr_ptr = (wr_ptr + 1) % wss_pkg::DEPTH;
            if (fill < wss_pkg::DEPTH - 1) fill++;
            n_push++;
         end
         wss_pkg::MODE_QUERY: begin
            stats_due.push_back(window_stats(it.time_ms));
            n_query++;
         end
         wss_pkg::MODE_CLEAR: begin
            wr_ptr = 0;
            fill = 0;
            n_clear++;
         end
         default: ;
      endcase
   endfunction

   // drive one item; start stays high when the next item follows at once
   task automatic send_item(logic [1:0] mode, logic signed [15:0] smp, logic [31:0] t);
      wss_pkg::req_type it;
      it.mode = mode;
      it.sample = smp;
      it.time_ms = t;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (busy);
      apply_item(it);
   endtask

   // drop start and let every outstanding result come back
   task automatic drain();
      start <= 1'b0;
      while (stats_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_window(logic [31:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      window_reg = value;
   endtask

   // result checker: rsp_valid is a one-cycle strobe
   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      wss_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         n_rsp++;
         if (stats_due.size() == 0) begin
            $display("%0t ns: unexpected result item %h", $time, rsp_data);
            errors++;
         end else begin
            want = stats_due.pop_front();
            check_field("count", want.count, rsp_data.count);
            check_field("empty_res", want.empty_res, rsp_data.empty_res);
            check_field("rate_mhz", want.rate_mhz, rsp_data.rate_mhz);
            check_field("mean", want.mean, rsp_data.mean);
            check_field("rms", want.rms, rsp_data.rms);
            check_field("minimum", want.minimum, rsp_data.minimum);
            check_field("maximum", want.maximum, rsp_data.maximum);
            check_field("crest_q8", want.crest_q8, rsp_data.crest_q8);
            check_field("newest", want.newest, rsp_data.newest);
         end
      end
   end

   // edge cases: empty ring, single sample, zero and negative span,
   // zero rms, future stamps, spare mode, both window extremes
   task automatic test_corner_cases();
      send_item(wss_pkg::MODE_QUERY, 16'sd0, 32'd100);          // empty ring
      send_item(wss_pkg::MODE_PUSH, 16'sd32767, 32'd100);
      send_item(wss_pkg::MODE_QUERY, 16'sd0, 32'd100);          // one sample
      send_item(wss_pkg::MODE_PUSH, 16'sh8000, 32'd100);
      send_item(wss_pkg::MODE_QUERY, 16'sd0, 32'd100);          // zero span
      send_item(wss_pkg::MODE_CLEAR, 16'sd0, 32'd200);
      send_item(wss_pkg::MODE_PUSH, 16'sd0, 32'd300);
      send_item(wss_pkg::MODE_QUERY, 16'sd0, 32'd300);          // all-zero window
      send_item(wss_pkg::MODE_PUSH, 16'sd5, 32'd250);           // time steps back
      send_item(wss_pkg::MODE_QUERY, 16'sd0, 32'd300);
      send_item(wss_pkg::MODE_PUSH, 16'sd7, 32'd5000);          // stamp in the future
      send_item(wss_pkg::MODE_QUERY, 16'sd0, 32'd400);
      send_item(MODE_SPARE, -16'sd1, 32'hFFFF_FFFF);            // ignored
      send_item(wss_pkg::MODE_QUERY, 16'sd0, 32'd30000);        // everything stale
      write_window(32'd0);
      send_item(wss_pkg::MODE_QUERY, 16'sd0, 32'd5000);
      write_window(32'hFFFF_FFFF);
      send_item(wss_pkg::MODE_PUSH, -16'sd1, 32'd5000);
      send_item(wss_pkg::MODE_PUSH, 16'sd1, 32'd5001);
      send_item(wss_pkg::MODE_QUERY, 16'sd0, 32'd30000);
   endtask

   // fill past the ring depth so the oldest entries get overwritten
   task automatic test_ring_wrap();
      write_window(32'hFFFF_FFFF);
      send_item(wss_pkg::MODE_CLEAR, 16'sd0, 32'd0);
      now_ms = $urandom_range(0, 32'h7FFF_FFFF);
      for (int i = 0; i < 1100; i++) begin
         now_ms += $urandom_range(0, 3);
         if (i % 150 == 149) send_item(wss_pkg::MODE_QUERY, 16'sd0, now_ms);
         else send_item(wss_pkg::MODE_PUSH, 16'($urandom), now_ms);
      end
   endtask

   // random traffic, mostly pushes with the odd query, clear or spare code
   task automatic test_random_traffic(int items, logic [31:0] base);
      int unsigned pick;
      logic signed [15:0] smp;
      now_ms = base;
      for (int i = 0; i < items; i++) begin
         if (now_ms < 32'hFFFF_F000) now_ms += $urandom_range(0, 40);
         pick = $urandom_range(0, 99);
         smp = ($urandom_range(0, 3) == 0) ? 16'($signed($urandom_range(0, 64)) - 32)
                                           : 16'($urandom);
         if (pick < 80) send_item(wss_pkg::MODE_PUSH, smp, now_ms);
         else if (pick < 95) send_item(wss_pkg::MODE_QUERY, smp, now_ms);
         else if (pick < 98) send_item(wss_pkg::MODE_CLEAR, smp, now_ms);
         else send_item(MODE_SPARE, smp, now_ms);
      end
   endtask

   // the sender holds off until every result has come back
   task automatic test_pause_on_drain();
      send_item(wss_pkg::MODE_QUERY, 16'sd0, now_ms);
      drain();
      send_item(wss_pkg::MODE_QUERY, 16'sd0, now_ms);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_corner_cases();
      test_ring_wrap();
      idle_pct = 37;
      write_window($urandom_range(50, 5000));
      test_random_traffic(230, $urandom_range(0, 32'h7FFF_FFFF));
      test_pause_on_drain();
      idle_pct = 66;
      write_window(32'd2000);
      test_random_traffic(230, 32'hFFF0_0000);
      idle_pct = 0;
      write_window(wss_pkg::WINDOW_RESET);
      test_random_traffic(230, $urandom_range(32'h8000_0000, 32'hF000_0000));
      start <= 1'b0;
      while (stats_due.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Covered %0d pushes, %0d queries, %0d clears; %0d results checked.",
               n_push, n_query, n_clear, n_rsp);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #500ms;
      $display("Timed out with %0d results outstanding.", stats_due.size());
      $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire
